[hw/rtl/bis_pkg.sv]
`timescale 1ns / 1ps

package bis_pkg;

  // Frame store geometry
  localparam int MAX_SRC_PIXELS = 262144;
  localparam int SRC_ADDR_W     = 18;
  localparam int PIX_W          = 24;
  localparam int CH_W           = 8;
  localparam int NUM_CH         = 3;

  // Field widths
  localparam int DIM_W = 10;
  localparam int DST_W = 13;
  localparam int IDX_W = 12;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_INTERP = 1'b1
  } func_t;

endpackage

[hw/rtl/bis_if.sv]
`timescale 1ns / 1ps

interface bis_in_if
  import bis_pkg::*;
();
  logic                  valid;
  logic                  ready;
  func_t                 func;
  logic [SRC_ADDR_W-1:0] src_index;
  logic [CH_W-1:0]       in_red;
  logic [CH_W-1:0]       in_green;
  logic [CH_W-1:0]       in_blue;
  logic [IDX_W-1:0]      out_col;
  logic [IDX_W-1:0]      out_row;

  modport source (
    output valid, func, src_index, in_red, in_green, in_blue, out_col, out_row,
    input  ready
  );

  modport sink (
    input  valid, func, src_index, in_red, in_green, in_blue, out_col, out_row,
    output ready
  );
endinterface

interface bis_out_if
  import bis_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

[hw/rtl/bilinear_image_scaler.sv]
// Bilinear RGB scaler. Load items (func 0) write one 24-bit pixel into the
// frame store; interpolate items (func 1) give one blended pixel each. One
// item is taken per cycle while the output is not held, loads and
// interpolates mixed freely, in order. The four neighbors come from two
// copies of the frame store, each read at two addresses per cycle, so no item
// waits on a memory port. A write to a size register starts a bit-serial
// division of the step ratio for that axis; items are not accepted until it
// completes. The frame store has no reset: reading a pixel that was never
// loaded returns whatever the memory holds.
`timescale 1ns / 1ps

module bilinear_image_scaler
  import bis_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bis_in_if.sink                in_if,
  bis_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int STEP_W  = DIM_W + FRAC_BITS;
  localparam int POS_W   = IDX_W + STEP_W;
  localparam int IP1_W   = POS_W - FRAC_BITS + 1;
  localparam int ONE_W   = FRAC_BITS + 1;
  localparam int WPROD_W = 2 * ONE_W;
  localparam int WGT_W   = 2 * FRAC_BITS + 1;
  localparam int PROD_W  = WGT_W + CH_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ROW_W   = 2 * DIM_W;
  localparam int CNT_W   = $clog2(STEP_W);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'((1 << FRAC_BITS) + 1);
  localparam logic [ONE_W-1:0]  ONE      = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } div_state_t;

  typedef struct packed {
    logic [DIM_W-1:0]     lo;
    logic [DIM_W-1:0]     hi;
    logic [FRAC_BITS-1:0] frac;
  } axis_t;

  function automatic axis_t split_axis(input logic [POS_W-1:0] pos,
                                       input logic [DIM_W-1:0] size);
    logic [IP1_W-1:0] ip1;
    axis_t            r;
    ip1 = {1'b0, pos[POS_W-1:FRAC_BITS]} + IP1_W'(1);
    if (ip1 >= IP1_W'(size)) begin
      r.lo   = size - DIM_W'(1);
      r.hi   = size - DIM_W'(1);
      r.frac = '0;
    end else begin
      r.lo   = pos[FRAC_BITS +: DIM_W];
      r.hi   = pos[FRAC_BITS +: DIM_W] + DIM_W'(1);
      r.frac = pos[FRAC_BITS-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [DIM_W-1:0] src_width_r, src_height_r;
  logic [DST_W-1:0] dst_width_r, dst_height_r;
  logic [DIM_W-1:0] src_w_eff, src_h_eff;
  logic [DST_W-1:0] dst_w_eff, dst_h_eff;
  logic             cfg_wr;
  cfg_reg_t         cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_reg = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(512);
      src_height_r <= DIM_W'(512);
      dst_width_r  <= DST_W'(512);
      dst_height_r <= DST_W'(512);
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_SRC_WIDTH:  src_width_r  <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= pwdata[DIM_W-1:0];
        REG_DST_WIDTH:  dst_width_r  <= pwdata[DST_W-1:0];
        REG_DST_HEIGHT: dst_height_r <= pwdata[DST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_SRC_WIDTH:  prdata = CFG_DATA_W'(src_width_r);
      REG_SRC_HEIGHT: prdata = CFG_DATA_W'(src_height_r);
      REG_DST_WIDTH:  prdata = CFG_DATA_W'(dst_width_r);
      REG_DST_HEIGHT: prdata = CFG_DATA_W'(dst_height_r);
      default:        prdata = '0;
    endcase
  end

  // a size of zero acts as one
  assign src_w_eff = (src_width_r == '0) ? DIM_W'(1) : src_width_r;
  assign src_h_eff = (src_height_r == '0) ? DIM_W'(1) : src_height_r;
  assign dst_w_eff = (dst_width_r == '0) ? DST_W'(1) : dst_width_r;
  assign dst_h_eff = (dst_height_r == '0) ? DST_W'(1) : dst_height_r;

  // ------------------------------------------------------- step divider
  div_state_t        div_state_r;
  logic [1:0]        div_pend_r, div_pend_nxt;
  logic [1:0]        div_start_mask, div_wr_mask;
  logic              div_axis_r;
  logic [STEP_W-1:0] div_num_r, div_quo_r, div_quo_nxt;
  logic [DST_W-1:0]  div_den_r;
  logic [DST_W:0]    div_rem_r, div_rem_sh, div_rem_nxt;
  logic              div_ge;
  logic [CNT_W-1:0]  div_cnt_r;
  logic [STEP_W-1:0] h_step_r, v_step_r;
  logic              div_start, div_done;

  always_comb begin
    div_wr_mask = 2'b00;
    if (cfg_wr) begin
      case (cfg_reg)
        REG_SRC_WIDTH, REG_DST_WIDTH:   div_wr_mask = 2'b01;
        REG_SRC_HEIGHT, REG_DST_HEIGHT: div_wr_mask = 2'b10;
        default:                        div_wr_mask = 2'b00;
      endcase
    end
  end

  assign div_start      = (div_state_r == DIV_IDLE) && (div_pend_r != 2'b00);
  assign div_start_mask = !div_start ? 2'b00 : (div_pend_r[0] ? 2'b01 : 2'b10);
  // a write during a run sets the flag again, so the axis is redone
  assign div_pend_nxt   = (div_pend_r & ~div_start_mask) | div_wr_mask;
  assign div_done       = (div_state_r == DIV_RUN) && (div_cnt_r == '0);

  assign div_rem_sh  = {div_rem_r[DST_W-1:0], div_num_r[STEP_W-1]};
  assign div_ge      = div_rem_sh >= {1'b0, div_den_r};
  assign div_rem_nxt = div_ge ? div_rem_sh - {1'b0, div_den_r} : div_rem_sh;
  assign div_quo_nxt = {div_quo_r[STEP_W-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
      div_pend_r  <= 2'b00;
      h_step_r    <= STEP_RST;
      v_step_r    <= STEP_RST;
    end else begin
      div_pend_r <= div_pend_nxt;
      case (div_state_r)
        DIV_IDLE: begin
          if (div_start) begin
            div_state_r <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (div_done) begin
            div_state_r <= DIV_IDLE;
            if (div_axis_r) begin
              v_step_r <= div_quo_nxt + STEP_W'(1);
            end else begin
              h_step_r <= div_quo_nxt + STEP_W'(1);
            end
          end
        end
        default: div_state_r <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_axis_r <= !div_pend_r[0];
      div_num_r  <= div_pend_r[0] ? {src_w_eff, {FRAC_BITS{1'b0}}}
                                  : {src_h_eff, {FRAC_BITS{1'b0}}};
      div_den_r  <= div_pend_r[0] ? dst_w_eff : dst_h_eff;
      div_rem_r  <= '0;
      div_quo_r  <= '0;
      div_cnt_r  <= CNT_W'(STEP_W - 1);
    end else if (div_state_r == DIV_RUN) begin
      div_num_r <= div_num_r << 1;
      div_rem_r <= div_rem_nxt;
      div_quo_r <= div_quo_nxt;
      div_cnt_r <= div_cnt_r - CNT_W'(1);
    end
  end

  // ------------------------------------------------------------ pipeline
  logic adv, in_ready, in_accept;
  logic out_valid_r;

  // the whole pipe moves together; the output register parts the two sides
  assign adv       = !out_valid_r || out_if.ready;
  assign in_ready  = adv && (div_state_r == DIV_IDLE) && (div_pend_r == 2'b00);
  assign in_accept = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // stage A: captured item
  logic                  a_valid_r;
  func_t                 a_func_r;
  logic [SRC_ADDR_W-1:0] a_index_r;
  logic [PIX_W-1:0]      a_pix_r;
  logic [IDX_W-1:0]      a_col_r, a_row_r;
  logic [POS_W-1:0]      a_pos_x, a_pos_y;

  // stage B: positions
  logic                  b_valid_r;
  func_t                 b_func_r;
  logic [SRC_ADDR_W-1:0] b_index_r;
  logic [PIX_W-1:0]      b_pix_r;
  logic [POS_W-1:0]      b_pos_x_r, b_pos_y_r;

  // stage C: neighbor coordinates and fractions
  logic                  c_valid_r;
  func_t                 c_func_r;
  logic [SRC_ADDR_W-1:0] c_index_r;
  logic [PIX_W-1:0]      c_pix_r;
  axis_t                 c_ax_r, c_ay_r;
  logic [ONE_W-1:0]      c_ofx, c_ofy;
  logic [WPROD_W-1:0]    c_wgt_full [4];

  // stage D: row bases and weights, store access
  logic                  d_valid_r;
  func_t                 d_func_r;
  logic [SRC_ADDR_W-1:0] d_index_r;
  logic [PIX_W-1:0]      d_pix_r;
  logic [DIM_W-1:0]      d_x0_r, d_x1_r;
  logic [ROW_W-1:0]      d_base0_r, d_base1_r;
  logic [WGT_W-1:0]      d_wgt_r [4];
  logic [SRC_ADDR_W-1:0] addr00, addr01, addr10, addr11;
  logic                  ram_we, ram_re;

  // stage E: pixels arrive from the store
  logic                  e_valid_r;
  logic [WGT_W-1:0]      e_wgt_r [4];
  logic [PIX_W-1:0]      e_pix [4];

  // stage F: weighted products
  logic                  f_valid_r;
  logic [PROD_W-1:0]     f_prod_r [NUM_CH][4];
  logic [SUM_W-1:0]      f_sum [NUM_CH];

  logic [CH_W-1:0]       out_pix_r [NUM_CH];

  assign a_pos_x = POS_W'(a_col_r) * POS_W'(h_step_r);
  assign a_pos_y = POS_W'(a_row_r) * POS_W'(v_step_r);

  assign c_ofx = ONE - {1'b0, c_ax_r.frac};
  assign c_ofy = ONE - {1'b0, c_ay_r.frac};
  assign c_wgt_full[0] = WPROD_W'(c_ofx) * WPROD_W'(c_ofy);
  assign c_wgt_full[1] = WPROD_W'(c_ax_r.frac) * WPROD_W'(c_ofy);
  assign c_wgt_full[2] = WPROD_W'(c_ofx) * WPROD_W'(c_ay_r.frac);
  assign c_wgt_full[3] = WPROD_W'(c_ax_r.frac) * WPROD_W'(c_ay_r.frac);

  // raster addresses wrap at the store depth
  assign addr00 = SRC_ADDR_W'(d_base0_r + ROW_W'(d_x0_r));
  assign addr01 = SRC_ADDR_W'(d_base0_r + ROW_W'(d_x1_r));
  assign addr10 = SRC_ADDR_W'(d_base1_r + ROW_W'(d_x0_r));
  assign addr11 = SRC_ADDR_W'(d_base1_r + ROW_W'(d_x1_r));
  assign ram_we = adv && d_valid_r && (d_func_r == FUNC_LOAD);
  assign ram_re = adv && d_valid_r && (d_func_r == FUNC_INTERP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_accept;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      // loads end at the store write
      e_valid_r   <= d_valid_r && (d_func_r == FUNC_INTERP);
      f_valid_r   <= e_valid_r;
      out_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_func_r  <= in_if.func;
      a_index_r <= in_if.src_index;
      a_pix_r   <= {in_if.in_red, in_if.in_green, in_if.in_blue};
      a_col_r   <= in_if.out_col;
      a_row_r   <= in_if.out_row;

      b_func_r  <= a_func_r;
      b_index_r <= a_index_r;
      b_pix_r   <= a_pix_r;
      b_pos_x_r <= a_pos_x;
      b_pos_y_r <= a_pos_y;

      c_func_r  <= b_func_r;
      c_index_r <= b_index_r;
      c_pix_r   <= b_pix_r;
      c_ax_r    <= split_axis(b_pos_x_r, src_w_eff);
      c_ay_r    <= split_axis(b_pos_y_r, src_h_eff);

      d_func_r  <= c_func_r;
      d_index_r <= c_index_r;
      d_pix_r   <= c_pix_r;
      d_x0_r    <= c_ax_r.lo;
      d_x1_r    <= c_ax_r.hi;
      d_base0_r <= ROW_W'(c_ay_r.lo) * ROW_W'(src_w_eff);
      d_base1_r <= ROW_W'(c_ay_r.hi) * ROW_W'(src_w_eff);
      for (int n = 0; n < 4; n++) begin
        d_wgt_r[n] <= c_wgt_full[n][WGT_W-1:0];
        e_wgt_r[n] <= d_wgt_r[n];
      end

      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int n = 0; n < 4; n++) begin
          f_prod_r[ch][n] <= PROD_W'(e_pix[n][PIX_W-1-ch*CH_W -: CH_W])
                             * PROD_W'(e_wgt_r[n]);
        end
        out_pix_r[ch] <= f_sum[ch][2*FRAC_BITS +: CH_W];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      f_sum[ch] = SUM_W'(f_prod_r[ch][0]) + SUM_W'(f_prod_r[ch][1])
                + SUM_W'(f_prod_r[ch][2]) + SUM_W'(f_prod_r[ch][3]);
    end
  end

  // two copies of the frame store: one for the upper row, one for the lower
  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SRC_PIXELS)
  ) u_ram_row0 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (d_index_r),
    .wdata   (d_pix_r),
    .re      (ram_re),
    .raddr_a (addr00),
    .raddr_b (addr01),
    .rdata_a (e_pix[0]),
    .rdata_b (e_pix[1])
  );

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SRC_PIXELS)
  ) u_ram_row1 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (d_index_r),
    .wdata   (d_pix_r),
    .re      (ram_re),
    .raddr_a (addr10),
    .raddr_b (addr11),
    .rdata_a (e_pix[2]),
    .rdata_b (e_pix[3])
  );

  assign out_if.valid     = out_valid_r;
  assign out_if.out_red   = out_pix_r[0];
  assign out_if.out_green = out_pix_r[1];
  assign out_if.out_blue  = out_pix_r[2];

`ifndef NO_ASSERTIONS
  ap_no_accept_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    ((div_state_r != DIV_IDLE) || (div_pend_r != 2'b00)) |-> !in_if.ready)
    else $error("item accepted while step ratio is being recomputed");

  ap_result_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && f_valid_r) |=> out_valid_r)
    else $error("interpolated item lost before output register");

  ap_ram_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("frame store read and write from the same stage");
`endif

endmodule

[hw/rtl/bis_ram.sv]
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[tb/sv/tb_bilinear_image_scaler.sv]
`timescale 1ns / 1ps

module tb_bilinear_image_scaler;
  import bis_pkg::*;

  localparam int FRAC = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {
    REG_SRC_WIDTH  = 0,
    REG_SRC_HEIGHT = 1,
    REG_DST_WIDTH  = 2,
    REG_DST_HEIGHT = 3
  } scaler_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef logic [SRC_ADDR_W-1:0] tap_addr_t [4];

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bis_in_if  in_ch ();
  bis_out_if out_ch ();

  bilinear_image_scaler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the frame store and the size registers
  pixel_t        frame_copy [MAX_SRC_PIXELS];
  bit            loaded_mask [MAX_SRC_PIXELS];
  logic [9:0]    src_w, src_h;
  logic [12:0]   dst_w, dst_h;
  logic [25:0]   h_step, v_step;
  pixel_t        expected_pixels [$];
  int            mismatch_count = 0;
  bit            in_gaps_on = 1'b1;
  bit            out_gaps_on = 1'b1;
  bit            hold_output = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned at_least_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void recompute_steps();
    longint unsigned num;
    num = at_least_one(src_w);
    h_step = (num << FRAC) / at_least_one(dst_w) + 1;
    num = at_least_one(src_h);
    v_step = (num << FRAC) / at_least_one(dst_h) + 1;
  endfunction

  // Integer part picks the neighbor pair, fraction is the blend weight
  function automatic void split_position(input longint unsigned pos, input int unsigned size,
                                         output int unsigned n0, output int unsigned n1,
                                         output longint unsigned frac);
    longint unsigned ip;
    ip = pos >> FRAC;
    if (ip + 1 >= size) begin
      n0 = size - 1;
      n1 = size - 1;
      frac = 0;
    end else begin
      n0 = ip;
      n1 = ip + 1;
      frac = pos & (ONE - 1);
    end
  endfunction

  function automatic logic [SRC_ADDR_W-1:0] tap_address(input int unsigned x, input int unsigned y,
                                                        input int unsigned w);
    longint unsigned a;
    a = y;
    a = a * w + x;
    return a[SRC_ADDR_W-1:0];
  endfunction

  function automatic void neighbor_taps(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                                        output tap_addr_t taps, output longint unsigned fx,
                                        output longint unsigned fy);
    int unsigned w, h, x0, x1, y0, y1;
    longint unsigned pos_x, pos_y;
    w = at_least_one(src_w);
    h = at_least_one(src_h);
    pos_x = col;
    pos_x = pos_x * h_step;
    pos_y = row;
    pos_y = pos_y * v_step;
    split_position(pos_x, w, x0, x1, fx);
    split_position(pos_y, h, y0, y1, fy);
    taps[0] = tap_address(x0, y0, w);
    taps[1] = tap_address(x1, y0, w);
    taps[2] = tap_address(x0, y1, w);
    taps[3] = tap_address(x1, y1, w);
  endfunction

  function automatic pixel_t blend_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    tap_addr_t       taps;
    longint unsigned fx, fy, sum;
    longint unsigned wt [4];
    logic [PIX_W-1:0] p [4];
    logic [PIX_W-1:0] res;
    neighbor_taps(col, row, taps, fx, fy);
    wt[0] = (ONE - fx) * (ONE - fy);
    wt[1] = fx * (ONE - fy);
    wt[2] = (ONE - fx) * fy;
    wt[3] = fx * fy;
    for (int i = 0; i < 4; i++) p[i] = frame_copy[taps[i]];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum = 0;
      for (int i = 0; i < 4; i++) sum += p[i][8*ch +: 8] * wt[i];
      res[8*ch +: 8] = sum[2*FRAC +: 8];
    end
    return res;
  endfunction

  // True when all four neighbors have been loaded
  function automatic bit interp_ok(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    tap_addr_t       taps;
    longint unsigned fx, fy;
    neighbor_taps(col, row, taps, fx, fy);
    return loaded_mask[taps[0]] && loaded_mask[taps[1]] &&
           loaded_mask[taps[2]] && loaded_mask[taps[3]];
  endfunction

  function automatic pixel_t random_pixel();
    logic [PIX_W-1:0] v;
    v = $urandom;
    return v;
  endfunction

  function automatic int unsigned pick_dst();
    case ($urandom_range(0, 3))
      0:       return 1;
      1:       return $urandom_range(2048, 4096);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  task automatic send_item(input func_t f, input logic [SRC_ADDR_W-1:0] idx, input pixel_t px,
                           input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.src_index <= idx;
    in_ch.in_red    <= px.red;
    in_ch.in_green  <= px.green;
    in_ch.in_blue   <= px.blue;
    in_ch.out_col   <= col;
    in_ch.out_row   <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (f == FUNC_LOAD) begin
      frame_copy[idx]  = px;
      loaded_mask[idx] = 1'b1;
    end else begin
      expected_pixels.push_back(blend_pixel(col, row));
    end
  endtask

  task automatic send_load(input logic [SRC_ADDR_W-1:0] idx, input pixel_t px);
    send_item(FUNC_LOAD, idx, px, $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic send_interp(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
    send_item(FUNC_INTERP, $urandom_range(0, MAX_SRC_PIXELS - 1), random_pixel(), col, row);
  endtask

  // Drop valid, let every pending pixel come out, then let the pipeline settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input scaler_reg_e r, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(r));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_SRC_WIDTH:  src_w = value[9:0];
      REG_SRC_HEIGHT: src_h = value[9:0];
      REG_DST_WIDTH:  dst_w = value[12:0];
      REG_DST_HEIGHT: dst_h = value[12:0];
      default: ;
    endcase
    recompute_steps();
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                              input logic [CFG_DATA_W-1:0] dw, input logic [CFG_DATA_W-1:0] dh);
    wait_drained();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
  endtask

  // Load the top-left lw x lh block of the source frame
  task automatic load_region(input int lw, input int lh);
    int w;
    w = at_least_one(src_w);
    for (int y = 0; y < lh; y++)
      for (int x = 0; x < lw; x++)
        send_load(y * w + x, random_pixel());
  endtask

  task automatic random_mix(input int n_ops, input int lw, input int lh);
    int   w, h, col_lim, row_lim;
    logic [IDX_W-1:0] col, row;
    bit   ok;
    w = at_least_one(src_w);
    h = at_least_one(src_h);
    col_lim = (at_least_one(dst_w) * lw) / w + 1;
    row_lim = (at_least_one(dst_h) * lh) / h + 1;
    if (col_lim > 4095) col_lim = 4095;
    if (row_lim > 4095) row_lim = 4095;
    repeat (n_ops) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 1))
          send_load($urandom_range(0, lh - 1) * w + $urandom_range(0, lw - 1), random_pixel());
        else
          send_load($urandom_range(0, MAX_SRC_PIXELS - 1), random_pixel());
      end else begin
        ok = 1'b0;
        for (int t = 0; t < 32 && !ok; t++) begin
          if ($urandom_range(0, 3) == 0) begin
            col = $urandom_range(0, 4095);
            row = $urandom_range(0, 4095);
          end else begin
            col = $urandom_range(0, col_lim);
            row = $urandom_range(0, row_lim);
          end
          ok = interp_ok(col, row);
        end
        if (!ok) begin
          col = '0;
          row = '0;
        end
        send_interp(col, row);
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [CH_W-1:0] want,
                                      input logic [CH_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: random stalls, one long hold on request, compare each pixel
  initial begin
    int     gap;
    pixel_t got, want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = out_gaps_on ? $urandom_range(0, 15) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = {out_ch.out_red, out_ch.out_green, out_ch.out_blue};
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: unexpected pixel: expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
      end
    end
  end

  // Reset sizes: 512x512 to 512x512, corner pixel and far clamp to the last pixel
  task automatic test_reset_config();
    send_load(0, 24'hFF0080);
    send_load(1, 24'h00FF01);
    send_load(512, 24'h7FFEFF);
    send_load(513, 24'hFFFF00);
    send_load(18'h3FFFF, 24'h55AA33);
    send_interp(0, 0);
    send_interp(12'hFFF, 12'hFFF);
  endtask

  // Upscale a 3x2 frame, including the last row and column and indexes past dst
  task automatic test_small_frame();
    pixel_t pats [6] = '{24'hFFFFFF, 24'h000000, 24'h123456, 24'hFEDCBA, 24'h80FF7F, 24'h01007E};
    set_geometry(3, 2, 7, 5);
    for (int i = 0; i < 6; i++) send_load(i, pats[i]);
    send_interp(0, 0);
    send_interp(3, 2);
    send_interp(6, 4);
    send_interp(2, 1);
    send_interp(12'hFFF, 12'hFFF);
  endtask

  // Width registers written as zero (upper bits set, masked off) act as one
  task automatic test_zero_size();
    set_geometry(32'hFFFF_FC00, 2, 32'hFFFF_E000, 5);
    send_interp(0, 0);
    send_interp(0, 3);
    send_interp(12'hFFF, 0);
    send_interp(0, 12'hFFF);
  endtask

  // Largest source and largest output; only the top-left corner is loaded
  task automatic test_full_scale_corner();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    set_geometry(512, 512, 4096, 4096);
    load_region(8, 8);
    random_mix(100, 8, 8);
  endtask

  task automatic test_single_pixel();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    set_geometry(1, 1, 1, 1);
    load_region(1, 1);
    random_mix(40, 1, 1);
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_backpressure();
    set_geometry(8, 8, 20, 13);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b1;
    load_region(8, 8);
    hold_output = 1'b1;
    random_mix(80, 8, 8);
  endtask

  task automatic test_random_frames();
    int w, h;
    repeat (5) begin
      w = $urandom_range(1, 16);
      h = $urandom_range(1, 16);
      set_geometry(w, h, pick_dst(), pick_dst());
      in_gaps_on  = $urandom_range(0, 1);
      out_gaps_on = $urandom_range(0, 1);
      load_region(w, h);
      random_mix(60, w, h);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_LOAD;
    in_ch.src_index <= '0;
    in_ch.in_red    <= '0;
    in_ch.in_green  <= '0;
    in_ch.in_blue   <= '0;
    in_ch.out_col   <= '0;
    in_ch.out_row   <= '0;
    src_w = 10'd512;
    src_h = 10'd512;
    dst_w = 13'd512;
    dst_h = 13'd512;
    recompute_steps();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_small_frame();
    test_zero_size();
    test_full_scale_corner();
    test_single_pixel();
    test_backpressure();
    test_random_frames();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bis_pkg.sv
hw/rtl/bis_if.sv
hw/rtl/bis_ram.sv
hw/rtl/bilinear_image_scaler.sv
tb/sv/tb_bilinear_image_scaler.sv
